// ----- sv/galvo_xy2_interp_serializer_top_defines.svh -----
// Assertion macros shared by the galvo serializer RTL.
`ifndef GALVO_XY2_INTERP_SERIALIZER_TOP_DEFINES_SVH
`define GALVO_XY2_INTERP_SERIALIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define GXY_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gxy: assertion failed");
// Checked at every edge, reset included.
`define GXY_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("gxy: assertion failed");
`else
`define GXY_ASSERT(lbl, prop)
`define GXY_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- sv/gxy_pkg.sv -----
package gxy_pkg;

	localparam int POS_W  = 16;
	localparam int PROD_W = 24;

	localparam logic [7:0]  RAMP_FRAMES_RST = 8'd10;
	localparam logic [15:0] STALE_LIMIT_RST = 16'd500;

	localparam logic REG_RAMP_FRAMES = 1'b0;
	localparam logic REG_STALE_LIMIT = 1'b1;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} gxy_state_t;

	typedef struct packed {
		logic        enabled;
		logic        stale;
		logic [15:0] seq;
		logic [15:0] count;
		logic [15:0] x;
		logic [15:0] y;
	} gxy_ser_cmd_t;

	typedef struct packed {
		logic             busy;
		logic [POS_W-1:0] pos;
	} gxy_div_stat_t;

	// Data bits followed by the even parity bit.
	function automatic logic [16:0] frame_core(input logic [15:0] data);
		return {data, ^data};
	endfunction

endpackage

// ----- sv/gxy_rdiv.sv -----
`include "galvo_xy2_interp_serializer_top_defines.svh"

module gxy_rdiv import gxy_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [POS_W-1:0] base,
	input  logic signed [POS_W-1:0] goal,
	input  logic [7:0]              k,
	input  logic [7:0]              n,
	output gxy_div_stat_t           stat
);
	localparam int CNT_W = $clog2(PROD_W);

	logic signed [POS_W:0] diff;
	logic [POS_W:0]        mag;
	logic                  mul_q;
	logic                  run_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [POS_W-1:0]      mag_q;
	logic                  neg_q;
	logic [7:0]            k_q;
	logic [7:0]            n_q;
	logic [POS_W-1:0]      base_q;
	logic [PROD_W-1:0]     dq_q;
	logic [7:0]            rem_q;
	logic [8:0]            trial;
	logic                  fits;

	assign diff  = $signed({goal[POS_W-1], goal}) - $signed({base[POS_W-1], base});
	assign mag   = diff[POS_W] ? (POS_W + 1)'(-diff) : diff;
	assign trial = {rem_q, dq_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q <= 1'b0;
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			mul_q <= 1'b1;
			run_q <= 1'b0;
		end else if (mul_q) begin
			mul_q <= 1'b0;
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(PROD_W - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// The product magnitude is divided one quotient bit per cycle, restoring form.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q  <= mag[POS_W-1:0];
			neg_q  <= diff[POS_W];
			k_q    <= k;
			n_q    <= n;
			base_q <= base;
		end else if (mul_q) begin
			dq_q  <= PROD_W'(mag_q) * PROD_W'(k_q);
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? 8'(trial - {1'b0, n_q}) : trial[7:0];
			dq_q  <= {dq_q[PROD_W-2:0], fits};
		end
	end

	// The quotient never exceeds the distance, so it fits the position width.
	assign stat.busy = mul_q | run_q;
	assign stat.pos  = neg_q ? base_q - dq_q[POS_W-1:0] : base_q + dq_q[POS_W-1:0];

	`GXY_ASSERT(a_one_phase, !(mul_q && run_q))

endmodule

// ----- sv/gxy_ser.sv -----
`include "galvo_xy2_interp_serializer_top_defines.svh"

module gxy_ser import gxy_pkg::*; #(
	parameter int FRAME_LEN = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         launch,
	input  gxy_ser_cmd_t cmd,
	output logic         ready,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,
	output logic         m_tuser,
	output logic         m_tlast
);
	localparam int REM_W = $clog2(FRAME_LEN + 1);

	logic [REM_W-1:0]     rem_q;
	logic [FRAME_LEN-1:0] xs_q;
	logic [FRAME_LEN-1:0] ys_q;
	logic                 en_q;
	logic                 stale_q;
	logic [15:0]          seq_q;
	logic [15:0]          cnt_q;
	logic                 m_tvalid_q;
	logic [39:0]          m_tdata_q;
	logic                 m_tuser_q;
	logic                 m_tlast_q;
	logic                 advance;
	logic                 shift;

	assign advance = !m_tvalid_q || m_tready;
	assign shift   = advance && (rem_q != '0);
	assign ready   = (rem_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (launch) begin
				rem_q <= cmd.enabled ? REM_W'(FRAME_LEN) : REM_W'(1);
			end else if (shift) begin
				rem_q <= rem_q - REM_W'(1);
			end
			if (advance) begin
				m_tvalid_q <= (rem_q != '0);
			end
		end
	end

	// A disabled tick loads zeros and a single word, which comes out as the idle word.
	always_ff @(posedge clk) begin
		if (launch) begin
			xs_q    <= cmd.enabled ? FRAME_LEN'(frame_core(cmd.x)) : '0;
			ys_q    <= cmd.enabled ? FRAME_LEN'(frame_core(cmd.y)) : '0;
			en_q    <= cmd.enabled;
			stale_q <= cmd.stale;
			seq_q   <= cmd.seq;
			cnt_q   <= cmd.count;
		end else if (shift) begin
			xs_q <= {xs_q[FRAME_LEN-2:0], 1'b0};
			ys_q <= {ys_q[FRAME_LEN-2:0], 1'b0};
		end
		if (shift) begin
			m_tdata_q <= {4'b0, cnt_q, seq_q, stale_q, en_q,
				ys_q[FRAME_LEN-1], xs_q[FRAME_LEN-1]};
			m_tuser_q <= en_q;
			m_tlast_q <= (rem_q == REM_W'(1));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`GXY_ASSERT(a_idle_word_last, (m_tvalid_q && !m_tuser_q) |-> m_tlast_q)

endmodule

// ----- sv/galvo_xy2_interp_serializer_top.sv -----
// Set-target word: accepted while idle, no output.
// Tick word: while a ramp runs, one multiply, then a 24-step bit-serial divider
// per axis, precede the first output word; then FRAME_LEN words (or one idle word)
// leave from the serializer shift registers at one per cycle unless m_tready stalls.
// The next word is taken as soon as the frame is loaded, so ticks overlap with output.
// arst_n asynchronously resets control state; divider and shifter data are not reset.
`include "galvo_xy2_interp_serializer_top_defines.svh"

module galvo_xy2_interp_serializer_top import gxy_pkg::*; #(
	parameter int FRAME_LEN = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // x_target, y_target, seq_number, ctrl_word
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // x_bit, y_bit, enabled_flag, stale_flag,
	                               // latest_sequence, frame_count, zero fill
	output logic        m_tuser,   // sync_level
	output logic        m_tlast,   // last_of_run
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	gxy_state_t          state_q;
	gxy_state_t          state_d;
	logic [7:0]          ramp_frames_q;
	logic [15:0]         stale_limit_q;
	logic signed [15:0]  pos_x_q;
	logic signed [15:0]  pos_y_q;
	logic signed [15:0]  start_x_q;
	logic signed [15:0]  start_y_q;
	logic signed [15:0]  goal_x_q;
	logic signed [15:0]  goal_y_q;
	logic [15:0]         seq_q;
	logic [15:0]         ctrl_q;
	logic [7:0]          ramp_step_q;
	logic [15:0]         idle_ticks_q;
	logic [15:0]         tick_count_q;
	logic                status_enabled_q;
	logic                status_stale_q;

	logic                accept;
	logic                acc_tick;
	logic                acc_set;
	logic                ramp_active;
	logic                div_start;
	logic                div_done;
	logic                ser_launch;
	logic                ser_ready;
	logic                changed;
	logic [7:0]          k_next;
	gxy_div_stat_t       x_stat;
	gxy_div_stat_t       y_stat;
	gxy_ser_cmd_t        ser_cmd;

	assign accept      = s_tvalid && s_tready;
	assign acc_tick    = accept && (s_tuser == OP_TICK);
	assign acc_set     = accept && (s_tuser == OP_SET);
	assign ramp_active = ramp_step_q < ramp_frames_q;
	assign k_next      = ramp_step_q + 8'd1;
	assign changed     = (s_tdata[47:32] != seq_q) || (s_tdata[15:0] != goal_x_q)
		|| (s_tdata[31:16] != goal_y_q) || (s_tdata[63:48] != ctrl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		div_start  = 1'b0;
		div_done   = 1'b0;
		ser_launch = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser == OP_TICK)) begin
					div_start = ramp_active;
					state_d   = ramp_active ? ST_DIV : ST_EMIT;
				end
			end
			ST_DIV: begin
				if (!x_stat.busy) begin
					div_done = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (ser_ready) begin
					ser_launch = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_frames_q <= RAMP_FRAMES_RST;
			stale_limit_q <= STALE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RAMP_FRAMES: ramp_frames_q <= cfg_data[7:0];
				REG_STALE_LIMIT: stale_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q          <= '0;
			pos_y_q          <= '0;
			start_x_q        <= '0;
			start_y_q        <= '0;
			goal_x_q         <= '0;
			goal_y_q         <= '0;
			seq_q            <= '0;
			ctrl_q           <= '0;
			ramp_step_q      <= RAMP_FRAMES_RST;
			idle_ticks_q     <= STALE_LIMIT_RST;
			tick_count_q     <= '0;
			status_enabled_q <= 1'b0;
			status_stale_q   <= 1'b1;
		end else begin
			if (acc_set && changed) begin
				start_x_q    <= pos_x_q;
				start_y_q    <= pos_y_q;
				goal_x_q     <= s_tdata[15:0];
				goal_y_q     <= s_tdata[31:16];
				seq_q        <= s_tdata[47:32];
				ctrl_q       <= s_tdata[63:48];
				idle_ticks_q <= '0;
				ramp_step_q  <= '0;
			end
			if (acc_tick) begin
				if (ramp_active) begin
					ramp_step_q <= k_next;
				end else begin
					pos_x_q <= goal_x_q;
					pos_y_q <= goal_y_q;
				end
				status_enabled_q <= ctrl_q[0];
				if (idle_ticks_q < stale_limit_q) begin
					idle_ticks_q   <= idle_ticks_q + 16'd1;
					status_stale_q <= 1'b0;
				end else begin
					status_stale_q <= 1'b1;
				end
				tick_count_q <= tick_count_q + 16'd1;
			end
			if (div_done) begin
				pos_x_q <= x_stat.pos;
				pos_y_q <= y_stat.pos;
			end
		end
	end

	gxy_rdiv u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.base   (start_x_q),
		.goal   (goal_x_q),
		.k      (k_next),
		.n      (ramp_frames_q),
		.stat   (x_stat)
	);

	gxy_rdiv u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.base   (start_y_q),
		.goal   (goal_y_q),
		.k      (k_next),
		.n      (ramp_frames_q),
		.stat   (y_stat)
	);

	assign ser_cmd.enabled = status_enabled_q;
	assign ser_cmd.stale   = status_stale_q;
	assign ser_cmd.seq     = seq_q;
	assign ser_cmd.count   = tick_count_q;
	assign ser_cmd.x       = pos_x_q;
	assign ser_cmd.y       = pos_y_q;

	gxy_ser #(
		.FRAME_LEN (FRAME_LEN)
	) u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.launch   (ser_launch),
		.cmd      (ser_cmd),
		.ready    (ser_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`GXY_ASSERT(a_div_runs, div_start |=> x_stat.busy)
	`GXY_ASSERT(a_tick_blocks, acc_tick |=> !s_tready)
	`GXY_ASSERT(a_axes_lockstep, x_stat.busy == y_stat.busy)

endmodule
